// ----- sv/baro_temp_pressure_compensation_defines.svh -----
// Assertion macros shared by the barometric compensation RTL.
// Included by the modules that carry concurrent assertions.
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_DEFINES_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define BTPC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("btpc assertion failed");

// Antecedent implies consequent in the next cycle.
`define BTPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("btpc assertion failed");

`endif

// ----- sv/btpc_pkg.sv -----
// Package for the barometric compensation block: types, codes and constants.
// Used by btpc_alu and baro_temp_pressure_compensation.
`default_nettype none
package btpc_pkg;

   localparam int unsigned WordW = 32;
   localparam int unsigned RawW = 19;
   localparam int unsigned CsrIdxW = 3;
   localparam int unsigned CntW = $clog2(WordW);

   localparam logic [WordW-1:0] ConstB6Off = 32'd4000;
   localparam logic [WordW-1:0] ConstC3038 = 32'd3038;
   localparam logic [WordW-1:0] ConstM7357 = 32'hFFFF_E343;
   localparam logic [WordW-1:0] ConstC3791 = 32'd3791;
   localparam logic [WordW-1:0] Const50000 = 32'd50000;
   localparam logic [WordW-1:0] Const32768 = 32'd32768;

   localparam logic [CsrIdxW-1:0] CSR_AC1_AC2 = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_AC3_AC4 = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_AC5_AC6 = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_B1_B2 = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_MC_MD = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_OSS = 3'd5;

   typedef enum logic {
      ALU_MUL = 1'b0,
      ALU_DIV = 1'b1
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } alu_stat_type;

   function automatic logic [WordW-1:0] sx16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

endpackage
`default_nettype wire

// ----- sv/baro_temp_pressure_compensation.sv -----
// Top level of the barometric compensation block: register file, sequencer
// and result register. Depends on btpc_pkg, btpc_alu and the defines header.
//
//   port group | direction | handshake        | payload
//   req_       | in        | valid / stall    | operation, raw_value
//   rsp_       | out       | valid / stall    | result_kind, value, divide_error
//   csr_       | in        | valid / ready    | index, data
//
// Each multiply or divide runs on the shared bit-serial unit.
// A zero divisor ends a temperature or pressure request early, with
// divide_error set and a zero value.
// One request is in flight at a time; req_stall is high while it is worked.
// A result held by rsp_stall waits in the output register; reset is synchronous.
`default_nettype none
`include "baro_temp_pressure_compensation_defines.svh"
module baro_temp_pressure_compensation (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic                         req_operation,
   input  wire logic [btpc_pkg::RawW-1:0]    req_raw_value,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic                              rsp_result_kind,
   output logic signed [btpc_pkg::WordW-1:0] rsp_value,
   output logic                              rsp_divide_error,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [btpc_pkg::CsrIdxW-1:0] csr_index,
   input  wire logic [btpc_pkg::WordW-1:0]   csr_data
);
   import btpc_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_START = 4'b0010,
      ST_WAIT  = 4'b0100,
      ST_OUT   = 4'b1000
   } state_type;

   typedef enum logic [12:0] {
      SP_T_MUL   = 13'b0_0000_0000_0001,
      SP_T_DIV   = 13'b0_0000_0000_0010,
      SP_SQ      = 13'b0_0000_0000_0100,
      SP_X1A     = 13'b0_0000_0000_1000,
      SP_X2A     = 13'b0_0000_0001_0000,
      SP_X1B     = 13'b0_0000_0010_0000,
      SP_X2B     = 13'b0_0000_0100_0000,
      SP_B4      = 13'b0_0000_1000_0000,
      SP_B7      = 13'b0_0001_0000_0000,
      SP_DIV     = 13'b0_0010_0000_0000,
      SP_PP      = 13'b0_0100_0000_0000,
      SP_P3038   = 13'b0_1000_0000_0000,
      SP_P7357   = 13'b1_0000_0000_0000
   } step_type;

   logic [WordW-1:0] ac12_ff, ac34_ff, ac56_ff, b12_ff, mcmd_ff;
   logic [1:0]       oss_ff;
   logic [WordW-1:0] b5_ff, b5_in;
   state_type        state_ff, state_in;
   step_type         step_ff, step_in;
   logic             kind_ff, kind_in;
   logic [RawW-1:0]  raw_ff, raw_in;
   logic [WordW-1:0] x1_ff, x1_in, x2_ff, x2_in, sq_ff, sq_in;
   logic [WordW-1:0] b3_ff, b3_in, b4_ff, b4_in, b7_ff, b7_in, p_ff, p_in;
   logic             neg_ff, neg_in;
   logic [WordW-1:0] val_ff, val_in;
   logic             err_ff, err_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_kind_ff, rsp_err_ff;
   logic [WordW-1:0] rsp_val_ff;

   alu_cmd_type      cmd;
   alu_stat_type     stat;
   logic [WordW-1:0] opa, opb, res;

   logic [WordW-1:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
   logic [WordW-1:0] b6, num, t0, t1, t2;
   logic             req_take, rsp_load;

   assign ac1 = sx16(ac12_ff[31:16]);
   assign ac2 = sx16(ac12_ff[15:0]);
   assign ac3 = sx16(ac34_ff[31:16]);
   assign ac4 = {16'b0, ac34_ff[15:0]};
   assign ac5 = {16'b0, ac56_ff[31:16]};
   assign ac6 = {16'b0, ac56_ff[15:0]};
   assign b1 = sx16(b12_ff[31:16]);
   assign b2 = sx16(b12_ff[15:0]);
   assign mc = sx16(mcmd_ff[31:16]);
   assign md = sx16(mcmd_ff[15:0]);
   assign b6 = b5_ff - ConstB6Off;
   assign num = {mc[20:0], 11'b0};

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take = req_valid && !req_stall;
   assign rsp_load = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      opa = '0;
      opb = '0;
      cmd.op = ALU_MUL;
      case (step_ff)
         SP_T_MUL: begin
            opa = {{(WordW - RawW){1'b0}}, raw_ff} - ac6;
            opb = ac5;
         end
         SP_T_DIV: begin
            cmd.op = ALU_DIV;
            opa = num[31] ? (32'd0 - num) : num;
            opb = x2_ff[31] ? (32'd0 - x2_ff) : x2_ff;
         end
         SP_SQ: begin
            opa = b6;
            opb = b6;
         end
         SP_X1A: begin
            opa = b2;
            opb = sq_ff;
         end
         SP_X2A: begin
            opa = ac2;
            opb = b6;
         end
         SP_X1B: begin
            opa = ac3;
            opb = b6;
         end
         SP_X2B: begin
            opa = b1;
            opb = sq_ff;
         end
         SP_B4: begin
            opa = ac4;
            opb = x2_ff + Const32768;
         end
         SP_B7: begin
            opa = {{(WordW - RawW){1'b0}}, raw_ff} - b3_ff;
            opb = Const50000 >> oss_ff;
         end
         SP_DIV: begin
            cmd.op = ALU_DIV;
            opa = b7_ff[31] ? b7_ff : {b7_ff[30:0], 1'b0};
            opb = b4_ff;
         end
         SP_PP: begin
            opa = 32'($signed(p_ff) >>> 8);
            opb = 32'($signed(p_ff) >>> 8);
         end
         SP_P3038: begin
            opa = x1_ff;
            opb = ConstC3038;
         end
         SP_P7357: begin
            opa = ConstM7357;
            opb = p_ff;
         end
         default: begin
            opa = '0;
         end
      endcase
      cmd.start = (state_ff == ST_START);
   end

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      kind_in = kind_ff;
      raw_in = raw_ff;
      x1_in = x1_ff;
      x2_in = x2_ff;
      sq_in = sq_ff;
      b3_in = b3_ff;
      b4_in = b4_ff;
      b7_in = b7_ff;
      p_in = p_ff;
      neg_in = neg_ff;
      b5_in = b5_ff;
      val_in = val_ff;
      err_in = err_ff;
      t0 = '0;
      t1 = '0;
      t2 = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               kind_in = req_operation;
               raw_in = req_raw_value;
               step_in = req_operation ? SP_SQ : SP_T_MUL;
               err_in = 1'b0;
               state_in = ST_START;
            end
         end
         ST_START: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (stat.done) begin
               state_in = ST_START;
               case (step_ff)
                  SP_T_MUL: begin
                     t0 = 32'($signed(res) >>> 15);
                     x1_in = t0;
                     t1 = t0 + md;
                     x2_in = t1;
                     neg_in = num[31] ^ t1[31];
                     if (t1 == '0) begin
                        val_in = '0;
                        err_in = 1'b1;
                        state_in = ST_OUT;
                     end else begin
                        step_in = SP_T_DIV;
                     end
                  end
                  SP_T_DIV: begin
                     t0 = neg_ff ? (32'd0 - res) : res;
                     t1 = x1_ff + t0;
                     b5_in = t1;
                     val_in = 32'($signed(t1 + 32'd8) >>> 4);
                     state_in = ST_OUT;
                  end
                  SP_SQ: begin
                     sq_in = 32'($signed(res) >>> 12);
                     step_in = SP_X1A;
                  end
                  SP_X1A: begin
                     x1_in = 32'($signed(res) >>> 11);
                     step_in = SP_X2A;
                  end
                  SP_X2A: begin
                     t0 = x1_ff + 32'($signed(res) >>> 11);
                     t1 = ({ac1[29:0], 2'b0} + t0) << oss_ff;
                     b3_in = 32'($signed(t1 + 32'd2) >>> 2);
                     step_in = SP_X1B;
                  end
                  SP_X1B: begin
                     x1_in = 32'($signed(res) >>> 13);
                     step_in = SP_X2B;
                  end
                  SP_X2B: begin
                     t0 = x1_ff + 32'($signed(res) >>> 16) + 32'd2;
                     x2_in = 32'($signed(t0) >>> 2);
                     step_in = SP_B4;
                  end
                  SP_B4: begin
                     b4_in = res >> 15;
                     step_in = SP_B7;
                  end
                  SP_B7: begin
                     b7_in = res;
                     if (b4_ff == '0) begin
                        val_in = '0;
                        err_in = 1'b1;
                        state_in = ST_OUT;
                     end else begin
                        step_in = SP_DIV;
                     end
                  end
                  SP_DIV: begin
                     p_in = b7_ff[31] ? {res[30:0], 1'b0} : res;
                     step_in = SP_PP;
                  end
                  SP_PP: begin
                     x1_in = res;
                     step_in = SP_P3038;
                  end
                  SP_P3038: begin
                     x1_in = 32'($signed(res) >>> 16);
                     step_in = SP_P7357;
                  end
                  SP_P7357: begin
                     t2 = x1_ff + 32'($signed(res) >>> 16) + ConstC3791;
                     val_in = p_ff + 32'($signed(t2) >>> 4);
                     state_in = ST_OUT;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_OUT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= SP_T_MUL;
         rsp_valid_ff <= 1'b0;
         b5_ff <= '0;
         ac12_ff <= '0;
         ac34_ff <= '0;
         ac56_ff <= '0;
         b12_ff <= '0;
         mcmd_ff <= '0;
         oss_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         b5_ff <= b5_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_AC1_AC2: ac12_ff <= csr_data;
               CSR_AC3_AC4: ac34_ff <= csr_data;
               CSR_AC5_AC6: ac56_ff <= csr_data;
               CSR_B1_B2:   b12_ff <= csr_data;
               CSR_MC_MD:   mcmd_ff <= csr_data;
               CSR_OSS:     oss_ff <= csr_data[1:0];
               default:     oss_ff <= oss_ff;
            endcase
         end
      end
      kind_ff <= kind_in;
      raw_ff <= raw_in;
      x1_ff <= x1_in;
      x2_ff <= x2_in;
      sq_ff <= sq_in;
      b3_ff <= b3_in;
      b4_ff <= b4_in;
      b7_ff <= b7_in;
      p_ff <= p_in;
      neg_ff <= neg_in;
      val_ff <= val_in;
      err_ff <= err_in;
      if (rsp_load) begin
         rsp_kind_ff <= kind_ff;
         rsp_val_ff <= val_ff;
         rsp_err_ff <= err_ff;
      end
   end

   btpc_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .opa    (opa),
      .opb    (opb),
      .stat   (stat),
      .result (res)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_value = $signed(rsp_val_ff);
   assign rsp_divide_error = rsp_err_ff;

   `BTPC_ASSERT_NEXT(a_take_starts, clock, reset, req_take, state_ff == ST_START)
   `BTPC_ASSERT_NOW(a_done_in_wait, clock, reset, stat.done, state_ff == ST_WAIT)
   `BTPC_ASSERT_NOW(a_step_onehot, clock, reset, 1'b1, $onehot(step_ff))
   `BTPC_ASSERT_NOW(a_err_zero, clock, reset, rsp_valid_ff && rsp_err_ff, rsp_val_ff == '0)

endmodule
`default_nettype wire

// ----- sv/btpc_alu.sv -----
// Shared bit-serial arithmetic unit: 32x32 shift-add multiply (low word)
// and 32-bit restoring unsigned divide, one bit per cycle. Uses btpc_pkg.
`default_nettype none
module btpc_alu (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire btpc_pkg::alu_cmd_type      cmd,
   input  wire logic [btpc_pkg::WordW-1:0] opa,
   input  wire logic [btpc_pkg::WordW-1:0] opb,
   output btpc_pkg::alu_stat_type          stat,
   output logic [btpc_pkg::WordW-1:0]      result
);
   import btpc_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   alu_op_type          op_ff, op_in;
   logic [CntW-1:0]     cnt_ff, cnt_in;
   logic [WordW:0]      acc_ff, acc_in;
   logic [WordW-1:0]    shr_ff, shr_in;
   logic [WordW-1:0]    opd_ff, opd_in;
   logic [WordW:0]      rem_sh;

   assign rem_sh = {acc_ff[WordW-1:0], shr_ff[WordW-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in = op_ff;
      cnt_in = cnt_ff;
      acc_in = acc_ff;
      shr_in = shr_ff;
      opd_in = opd_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         op_in = cmd.op;
         cnt_in = '0;
         acc_in = '0;
         shr_in = (cmd.op == ALU_MUL) ? opb : opa;
         opd_in = (cmd.op == ALU_MUL) ? opa : opb;
      end else if (busy_ff) begin
         case (op_ff)
            ALU_MUL: begin
               if (shr_ff[0]) begin
                  acc_in = {1'b0, acc_ff[WordW-1:0] + opd_ff};
               end
               opd_in = {opd_ff[WordW-2:0], 1'b0};
               shr_in = {1'b0, shr_ff[WordW-1:1]};
            end
            ALU_DIV: begin
               if (rem_sh >= {1'b0, opd_ff}) begin
                  acc_in = rem_sh - {1'b0, opd_ff};
                  shr_in = {shr_ff[WordW-2:0], 1'b1};
               end else begin
                  acc_in = rem_sh;
                  shr_in = {shr_ff[WordW-2:0], 1'b0};
               end
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CntW'(WordW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff <= op_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      shr_ff <= shr_in;
      opd_ff <= opd_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign result = (op_ff == ALU_MUL) ? acc_ff[WordW-1:0] : shr_ff;

endmodule
`default_nettype wire
